// File: rtl/mc_grp_pkg.sv
package mc_grp_pkg;

    localparam int SLOTS    = 8;
    localparam int REF_BITS = 16;
    localparam int SLOT_W   = 3;
    localparam int ADDR_W   = 64;

    localparam logic KIND_JOIN  = 1'b0;
    localparam logic KIND_LEAVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } chain_t;

    typedef struct packed {
        logic                sel;
        logic [REF_BITS-1:0] refs;
    } cell_res_t;

endpackage

// File: rtl/multicast_group_refcount_table_top.sv
// Result strobe (done): registered from busy, which is registered from the accepted start.
// A new transaction is accepted only while busy is low; busy is high for the one cycle in
// which the row of slot cells resolves match and free priority and updates its entry.
// Reset: asynchronous, active low; clears all used marks and counts; addresses are
// undefined until allocated. Results cannot be stalled by the receiver.
module multicast_group_refcount_table_top
    import mc_grp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              kind,
    input  logic [ADDR_W-1:0] addr_high,
    input  logic [ADDR_W-1:0] addr_low,
    output logic              done,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot,
    output logic [15:0]       ref_count
);

    logic                busy_reg;
    logic                done_reg;
    logic                kind_reg;
    logic [ADDR_W-1:0]   high_reg;
    logic [ADDR_W-1:0]   low_reg;
    status_t             status_reg;
    status_t             status_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [REF_BITS-1:0] refs_reg;
    logic [REF_BITS-1:0] refs_next;
    logic                capture;
    chain_t              chain [SLOTS+1];
    cell_res_t           res   [SLOTS];
    logic [SLOTS-1:0]    sel_vec;

    assign capture = start && !busy_reg;
    assign chain[0] = '{hit_seen: 1'b0, free_seen: 1'b0};

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        mc_grp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .capture   (capture),
            .commit    (busy_reg),
            .kind      (kind_reg),
            .cmp_high  (addr_high),
            .cmp_low   (addr_low),
            .req_high  (high_reg),
            .req_low   (low_reg),
            .any_hit   (chain[SLOTS].hit_seen),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .res       (res[i])
        );
        assign sel_vec[i] = res[i].sel;
    end

    always_comb
    begin
        slot_next = '0;
        refs_next = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (res[i].sel)
            begin
                slot_next = slot_next | SLOT_W'(i);
                refs_next = refs_next | res[i].refs;
            end
        end
        if (chain[SLOTS].hit_seen)
            status_next = ST_OK;
        else if (kind_reg == KIND_LEAVE)
            status_next = ST_NOT_FOUND;
        else if (chain[SLOTS].free_seen)
            status_next = ST_OK;
        else
            status_next = ST_FULL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= capture;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            kind_reg <= kind;
            high_reg <= addr_high;
            low_reg  <= addr_low;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            refs_reg   <= refs_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign ref_count = refs_reg;

`ifndef NO_ASSERTIONS
    a_done_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> done_reg)
        else $error("result strobe missing after update cycle");

    a_single_select: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(sel_vec))
        else $error("more than one slot selected");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (slot_reg == '0 && refs_reg == '0))
        else $error("failed transaction reports nonzero slot or count");

    a_ok_selects: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && status_next == ST_OK) |-> $onehot(sel_vec))
        else $error("successful transaction without a selected slot");
`endif

endmodule

// File: rtl/mc_grp_cell.sv
module mc_grp_cell
    import mc_grp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              capture,
    input  logic              commit,
    input  logic              kind,
    input  logic [ADDR_W-1:0] cmp_high,
    input  logic [ADDR_W-1:0] cmp_low,
    input  logic [ADDR_W-1:0] req_high,
    input  logic [ADDR_W-1:0] req_low,
    input  logic              any_hit,
    input  chain_t            chain_in,
    output chain_t            chain_out,
    output cell_res_t         res
);

    logic [ADDR_W-1:0]   high_reg;
    logic [ADDR_W-1:0]   low_reg;
    logic                used_reg;
    logic                used_next;
    logic [REF_BITS-1:0] refs_reg;
    logic [REF_BITS-1:0] refs_next;
    logic                hit_reg;
    logic                hit_next;
    logic                take_hit;
    logic                take_free;
    logic                alloc;

    assign hit_next  = used_reg && (high_reg == cmp_high) && (low_reg == cmp_low);
    assign take_hit  = hit_reg && !chain_in.hit_seen;
    assign take_free = !used_reg && !chain_in.free_seen;
    assign alloc     = (kind == KIND_JOIN) && !any_hit && take_free;

    assign chain_out.hit_seen  = chain_in.hit_seen || hit_reg;
    assign chain_out.free_seen = chain_in.free_seen || !used_reg;

    always_comb
    begin
        refs_next = refs_reg;
        used_next = used_reg;
        if (take_hit)
        begin
            if (kind == KIND_JOIN)
            begin
                if (refs_reg != {REF_BITS{1'b1}})
                    refs_next = refs_reg + REF_BITS'(1);
            end
            else
            begin
                if (refs_reg != '0)
                    refs_next = refs_reg - REF_BITS'(1);
            end
        end
        else if (alloc)
        begin
            refs_next = REF_BITS'(1);
            used_next = 1'b1;
        end
    end

    assign res.sel  = take_hit || alloc;
    assign res.refs = refs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            refs_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (capture)
                hit_reg <= hit_next;
            if (commit)
            begin
                used_reg <= used_next;
                refs_reg <= refs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && alloc)
        begin
            high_reg <= req_high;
            low_reg  <= req_low;
        end
    end

endmodule

// File: bench/tb_multicast_group_refcount_table_top.sv
module tb_multicast_group_refcount_table_top
    import mc_grp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 500;
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        int unsigned       gap;
        bit                drain;
    } grp_request_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       ref_count;
    } grp_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              kind;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic              done;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       ref_count;

    grp_request_t pending_q[$];
    grp_result_t  expected_q[$];

    logic [ADDR_W-1:0]   tbl_hi   [SLOTS];
    logic [ADDR_W-1:0]   tbl_lo   [SLOTS];
    logic                tbl_used [SLOTS];
    logic [REF_BITS-1:0] tbl_refs [SLOTS];

    logic [ADDR_W-1:0] pool_hi [SLOTS];
    logic [ADDR_W-1:0] pool_lo [SLOTS];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    multicast_group_refcount_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .addr_high (addr_high),
        .addr_low  (addr_low),
        .done      (done),
        .status    (status),
        .slot      (slot),
        .ref_count (ref_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic grp_result_t apply_request(logic k, logic [ADDR_W-1:0] hi,
                                                  logic [ADDR_W-1:0] lo);
        grp_result_t res;
        int          hit;
        int          free_slot;
        res.status    = ST_OK;
        res.slot      = '0;
        res.ref_count = '0;
        hit           = -1;
        free_slot     = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (tbl_used[i] && tbl_hi[i] == hi && tbl_lo[i] == lo)
                hit = i;
            if (!tbl_used[i])
                free_slot = i;
        end
        if (k == KIND_JOIN)
        begin
            if (hit >= 0)
            begin
                if (tbl_refs[hit] != REF_MAX)
                    tbl_refs[hit] = tbl_refs[hit] + 1'b1;
                res.slot      = SLOT_W'(hit);
                res.ref_count = 16'(tbl_refs[hit]);
            end
            else if (free_slot >= 0)
            begin
                tbl_hi[free_slot]   = hi;
                tbl_lo[free_slot]   = lo;
                tbl_used[free_slot] = 1'b1;
                tbl_refs[free_slot] = REF_BITS'(1);
                res.slot            = SLOT_W'(free_slot);
                res.ref_count       = 16'd1;
            end
            else
                res.status = ST_FULL;
        end
        else
        begin
            if (hit >= 0)
            begin
                if (tbl_refs[hit] != '0)
                    tbl_refs[hit] = tbl_refs[hit] - 1'b1;
                res.slot      = SLOT_W'(hit);
                res.ref_count = 16'(tbl_refs[hit]);
            end
            else
                res.status = ST_NOT_FOUND;
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_half();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_request(logic k, logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo,
                                 int unsigned gap, bit drain);
        grp_request_t req;
        req.kind  = k;
        req.hi    = hi;
        req.lo    = lo;
        req.gap   = gap;
        req.drain = drain;
        pending_q.push_back(req);
    endtask

    // driver: present queued transactions, hold start until accepted
    always @(posedge clk or negedge rst_n)
    begin
        bit           launch;
        grp_request_t req;
        if (!rst_n)
        begin
            start     <= 1'b0;
            kind      <= KIND_JOIN;
            addr_high <= '0;
            addr_low  <= '0;
        end
        else
        begin
            launch = start;
            if (start && !busy)
            begin
                expected_q.push_back(apply_request(kind, addr_high, addr_low));
                launch = 1'b0;
            end
            if (!launch && pending_q.size() > 0)
            begin
                if (pending_q[0].gap > 0)
                    pending_q[0].gap--;
                else if (!(pending_q[0].drain && expected_q.size() != 0))
                begin
                    req       = pending_q.pop_front();
                    kind      <= req.kind;
                    addr_high <= req.hi;
                    addr_low  <= req.lo;
                    launch    = 1'b1;
                end
            end
            start <= launch;
        end
    end

    // monitor: compare each result against the oldest expectation
    always @(posedge clk)
    begin
        grp_result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: status=%0d slot=%0d ref_count=%0d",
                       status, slot, ref_count);
                error_count++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, status);
                    error_count++;
                end
                if (slot !== exp_res.slot)
                begin
                    $error("slot: expected %0d, actual %0d", exp_res.slot, slot);
                    error_count++;
                end
                if (ref_count !== exp_res.ref_count)
                begin
                    $error("ref_count: expected %0d, actual %0d",
                           exp_res.ref_count, ref_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic              k;
        int unsigned       idx;
        int unsigned       r;
        bit                quiet;

        rst_n = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_hi[i]   = '0;
            tbl_lo[i]   = '0;
            tbl_used[i] = 1'b0;
            tbl_refs[i] = '0;
        end

        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[2] = '1;
        pool_lo[2] = '0;
        pool_hi[3] = '0;
        pool_lo[3] = '1;
        for (int i = 4; i < SLOTS; i++)
        begin
            pool_hi[i] = rand_half();
            pool_lo[i] = rand_half();
        end

        // leave on an empty table, then count up, down and past zero
        queue_request(KIND_LEAVE, pool_hi[0], pool_lo[0], 0, 0);
        queue_request(KIND_JOIN,  pool_hi[0], pool_lo[0], pick_gap(), 0);
        queue_request(KIND_JOIN,  pool_hi[0], pool_lo[0], 0, 0);
        queue_request(KIND_LEAVE, pool_hi[0], pool_lo[0], pick_gap(), 0);
        queue_request(KIND_LEAVE, pool_hi[0], pool_lo[0], 0, 0);
        queue_request(KIND_LEAVE, pool_hi[0], pool_lo[0], 0, 0);
        queue_request(KIND_JOIN,  pool_hi[0], pool_lo[0], pick_gap(), 0);
        // fill the remaining slots
        for (int i = 1; i < SLOTS; i++)
            queue_request(KIND_JOIN, pool_hi[i], pool_lo[i], pick_gap(), 0);
        // table full on join, miss on leave
        hi = rand_half();
        lo = rand_half();
        queue_request(KIND_JOIN,  hi, lo, 0, 0);
        queue_request(KIND_LEAVE, hi, lo, pick_gap(), 0);
        queue_request(KIND_LEAVE, pool_hi[1], pool_lo[1], 0, 0);
        queue_request(KIND_JOIN,  pool_hi[1], pool_lo[1], 0, 0);
        queue_request(KIND_LEAVE, pool_hi[2], pool_lo[2] ^ 64'h1, 0, 0);

        queue_request(KIND_LEAVE, pool_hi[0], pool_lo[0], 0, 0);
        queue_request(KIND_JOIN,  pool_hi[0], pool_lo[0], 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = ((i / 50) % 3) == 1;
            k     = 1'($urandom_range(0, 1));
            idx   = $urandom_range(0, SLOTS - 1);
            r     = $urandom_range(0, 99);
            hi    = pool_hi[idx];
            lo    = pool_lo[idx];
            if (r >= 90)
            begin
                hi = rand_half();
                lo = rand_half();
            end
            else if (r >= 80)
            begin
                // near miss: flip one address bit
                if ($urandom_range(0, 1))
                    hi[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
                else
                    lo[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
            end
            queue_request(k, hi, lo, quiet ? 0 : pick_gap(), (i % 100) == 0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || expected_q.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/mc_grp_pkg.sv
rtl/mc_grp_cell.sv
rtl/multicast_group_refcount_table_top.sv
bench/tb_multicast_group_refcount_table_top.sv
